>>> sv/segment_intersection_test_defines.svh
// Assertion macros for the port-level checker of the segment intersection test.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// Next-cycle implication, checked outside reset.
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

// Next-cycle implication that also holds across reset.
`define SIT_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("segment intersection reset check failed");

`endif

>>> sv/sit_pkg.sv
// Shared types and constants of the segment intersection test.
package sit_pkg;

  typedef enum logic [1:0] {
    TURN_COLLINEAR = 2'd0,
    TURN_CW        = 2'd1,
    TURN_CCW       = 2'd2
  } turn_t;

  // Point slots: 0 = A start, 1 = A end, 2 = B start, 3 = B end.
  // Orientation k looks at the ordered triple (TURN_A, TURN_B, TURN_C); the
  // bounding box test of that orientation checks TURN_C against segment
  // TURN_A-TURN_B.
  localparam logic [1:0] TURN_A [4] = '{2'd0, 2'd0, 2'd2, 2'd2};
  localparam logic [1:0] TURN_B [4] = '{2'd1, 2'd1, 2'd3, 2'd3};
  localparam logic [1:0] TURN_C [4] = '{2'd2, 2'd3, 2'd0, 2'd1};

  typedef struct packed {
    turn_t [3:0] turn;
    logic  [3:0] box;
  } turn_info_t;

endpackage

>>> sv/sit_diff.sv
// Stage one: coordinate differences for the four cross products and the box tests.
module sit_diff
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] px [4],
  input  logic signed [COORD_WIDTH-1:0] py [4],
  output logic                          valid,
  output logic signed [COORD_WIDTH:0]   dy_ab [4],
  output logic signed [COORD_WIDTH:0]   dx_bc [4],
  output logic signed [COORD_WIDTH:0]   dx_ab [4],
  output logic signed [COORD_WIDTH:0]   dy_bc [4],
  output logic [3:0]                    box
);

  localparam int W = COORD_WIDTH;

  logic signed [W:0] dy_ab_next [4];
  logic signed [W:0] dx_bc_next [4];
  logic signed [W:0] dx_ab_next [4];
  logic signed [W:0] dy_bc_next [4];
  logic [3:0]        box_next;

  for (genvar k = 0; k < 4; k++) begin : g_turn
    localparam logic [1:0] IA = TURN_A[k];
    localparam logic [1:0] IB = TURN_B[k];
    localparam logic [1:0] IC = TURN_C[k];

    // One extra bit keeps every difference exact.
    assign dy_ab_next[k] = $signed({py[IB][W-1], py[IB]}) - $signed({py[IA][W-1], py[IA]});
    assign dx_bc_next[k] = $signed({px[IC][W-1], px[IC]}) - $signed({px[IB][W-1], px[IB]});
    assign dx_ab_next[k] = $signed({px[IB][W-1], px[IB]}) - $signed({px[IA][W-1], px[IA]});
    assign dy_bc_next[k] = $signed({py[IC][W-1], py[IC]}) - $signed({py[IB][W-1], py[IB]});

    // Inside [min, max] is the same as below one end and above one end.
    assign box_next[k] =
        ((px[IC] <= px[IA]) || (px[IC] <= px[IB])) &&
        ((px[IC] >= px[IA]) || (px[IC] >= px[IB])) &&
        ((py[IC] <= py[IA]) || (py[IC] <= py[IB])) &&
        ((py[IC] >= py[IA]) || (py[IC] >= py[IB]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dy_ab <= dy_ab_next;
      dx_bc <= dx_bc_next;
      dx_ab <= dx_ab_next;
      dy_bc <= dy_bc_next;
      box   <= box_next;
    end
  end

endmodule

>>> sv/sit_cross.sv
// Stages two and three: cross product terms, then their difference reduced to a turn code.
module sit_cross
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en_mul,
  input  logic                        en_sign,
  input  logic                        in_valid,
  input  logic signed [COORD_WIDTH:0] dy_ab [4],
  input  logic signed [COORD_WIDTH:0] dx_bc [4],
  input  logic signed [COORD_WIDTH:0] dx_ab [4],
  input  logic signed [COORD_WIDTH:0] dy_bc [4],
  input  logic [3:0]                  box,
  output logic                        mul_valid,
  output logic                        valid,
  output turn_info_t                  info
);

  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int XW = PW + 1;

  logic signed [PW-1:0] p1 [4];
  logic signed [PW-1:0] p2 [4];
  logic signed [PW-1:0] p1_next [4];
  logic signed [PW-1:0] p2_next [4];
  logic [3:0]           mul_box;
  turn_info_t           info_next;

  for (genvar k = 0; k < 4; k++) begin : g_turn
    logic signed [XW-1:0] cross_sum;

    assign p1_next[k] = PW'(dy_ab[k]) * PW'(dx_bc[k]);
    assign p2_next[k] = PW'(dx_ab[k]) * PW'(dy_bc[k]);

    assign cross_sum = XW'(p1[k]) - XW'(p2[k]);

    // A nonzero sum with the sign bit clear is a clockwise turn.
    assign info_next.turn[k] = (cross_sum == '0)     ? TURN_COLLINEAR :
                               cross_sum[XW-1]       ? TURN_CCW :
                                                       TURN_CW;
  end

  assign info_next.box = mul_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (en_mul) begin
        mul_valid <= in_valid;
      end
      if (en_sign) begin
        valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p1      <= p1_next;
      p2      <= p2_next;
      mul_box <= box;
    end
    if (en_sign) begin
      info <= info_next;
    end
  end

endmodule

>>> sv/sit_decide.sv
// Stage four: combines the turn codes and box tests into the result register.
module sit_decide
  import sit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  turn_info_t info,
  output logic       valid,
  output logic       hit
);

  logic [3:0] collinear;
  logic       hit_next;

  for (genvar k = 0; k < 4; k++) begin : g_col
    assign collinear[k] = (info.turn[k] == TURN_COLLINEAR);
  end

  // Proper crossing, or a collinear endpoint that sits on the other segment.
  assign hit_next = ((info.turn[0] != info.turn[1]) && (info.turn[2] != info.turn[3])) ||
                    (|(collinear & info.box));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule

>>> sv/segment_intersection_test.sv
// Top level of the segment intersection test: four-stage pipeline and its flow control.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_stall  seg_a_* and seg_b_* coordinates
//   out       result     out_valid / out_stall  segments_intersect
//
// One request enters per cycle while in_stall is low, even with others still in flight.
// The stages are differences, products, product difference with sign, and the result.
// Reset is synchronous and clears only the stage valid bits.
// A stage advances when it is empty or the stage after it advances, so bubbles fill up
// under a stall and in_stall rises only when all four stages hold requests.
module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          segments_intersect
);

  logic signed [COORD_WIDTH-1:0] px [4];
  logic signed [COORD_WIDTH-1:0] py [4];

  logic signed [COORD_WIDTH:0] dy_ab [4];
  logic signed [COORD_WIDTH:0] dx_bc [4];
  logic signed [COORD_WIDTH:0] dx_ab [4];
  logic signed [COORD_WIDTH:0] dy_bc [4];
  logic [3:0]                  box;

  logic       diff_valid;
  logic       mul_valid;
  logic       cross_valid;
  turn_info_t info;

  logic en_diff;
  logic en_mul;
  logic en_sign;
  logic en_out;

  assign px[0] = seg_a_start_x;
  assign py[0] = seg_a_start_y;
  assign px[1] = seg_a_end_x;
  assign py[1] = seg_a_end_y;
  assign px[2] = seg_b_start_x;
  assign py[2] = seg_b_start_y;
  assign px[3] = seg_b_end_x;
  assign py[3] = seg_b_end_y;

  // Each enable looks at its own stage's valid bit and the enable or stall after it.
  assign en_out   = !out_valid || !out_stall;
  assign en_sign  = !cross_valid || en_out;
  assign en_mul   = !mul_valid || en_sign;
  assign en_diff  = !diff_valid || en_mul;
  assign in_stall = !en_diff;

  sit_diff #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_diff (
    .clk     (clk),
    .rst     (rst),
    .en      (en_diff),
    .in_valid(in_valid),
    .px      (px),
    .py      (py),
    .valid   (diff_valid),
    .dy_ab   (dy_ab),
    .dx_bc   (dx_bc),
    .dx_ab   (dx_ab),
    .dy_bc   (dy_bc),
    .box     (box)
  );

  sit_cross #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .en_mul   (en_mul),
    .en_sign  (en_sign),
    .in_valid (diff_valid),
    .dy_ab    (dy_ab),
    .dx_bc    (dx_bc),
    .dx_ab    (dx_ab),
    .dy_bc    (dy_bc),
    .box      (box),
    .mul_valid(mul_valid),
    .valid    (cross_valid),
    .info     (info)
  );

  sit_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .en      (en_out),
    .in_valid(cross_valid),
    .info    (info),
    .valid   (out_valid),
    .hit     (segments_intersect)
  );

endmodule

>>> sv/sit_checker.sv
// Port-level checks of the segment intersection test and their binding.
`include "segment_intersection_test_defines.svh"

module sit_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic segments_intersect
);

  // Nothing leaves the pipeline in the cycle after reset.
  `SIT_ASSERT_RST(a_reset_empty, rst, !out_valid)

  // The input side is held back only when a finished result is stuck at the output.
  `SIT_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall)

  // A request accepted while out_stall stays low as it moves through the stages comes out at the output.
  `SIT_ASSERT_NEXT(a_latency,
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall,
    out_valid)

  // A stalled result stays put.
  `SIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(segments_intersect))

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

>>> bench/tb.sv
// Self-checking testbench for the segment intersection test block.
module tb
  import sit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = 16;
  localparam int COORD_MIN = -32768;
  localparam int COORD_MAX = 32767;
  localparam int EDGE_VALUES [8] = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};
  localparam int RANDOM_PAIRS = 430;

  // Point slots follow the package: 0 A start, 1 A end, 2 B start, 3 B end.
  typedef struct packed {
    logic [3:0][COORD_W-1:0] x;
    logic [3:0][COORD_W-1:0] y;
  } seg_pair_t;

  class intersect_board;
    bit expected_hits[$];
    int mismatches;
    int checked;
    int hits;
    int misses;

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", checked, what);
      mismatches++;
    endtask

    function turn_t orientation(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
      longint cross_sum;
      cross_sum = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
      if (cross_sum == 0) return TURN_COLLINEAR;
      return (cross_sum > 0) ? TURN_CW : TURN_CCW;
    endfunction

    function bit in_bounds(longint ex0, longint ey0, longint ex1, longint ey1,
                           longint mx, longint my);
      longint lo_x, hi_x, lo_y, hi_y;
      lo_x = (ex0 < ex1) ? ex0 : ex1;
      hi_x = (ex0 < ex1) ? ex1 : ex0;
      lo_y = (ey0 < ey1) ? ey0 : ey1;
      hi_y = (ey0 < ey1) ? ey1 : ey0;
      return mx >= lo_x && mx <= hi_x && my >= lo_y && my <= hi_y;
    endfunction

    function bit predict_hit(seg_pair_t p);
      longint px[4];
      longint py[4];
      turn_t  t[4];
      bit     hit;
      for (int i = 0; i < 4; i++) begin
        px[i] = $signed(p.x[i]);
        py[i] = $signed(p.y[i]);
      end
      for (int k = 0; k < 4; k++) begin
        t[k] = orientation(px[TURN_A[k]], py[TURN_A[k]], px[TURN_B[k]], py[TURN_B[k]],
                           px[TURN_C[k]], py[TURN_C[k]]);
      end
      hit = (t[0] != t[1]) && (t[2] != t[3]);
      // A collinear endpoint only counts when it sits within the other segment's box.
      for (int k = 0; k < 4; k++) begin
        if (t[k] == TURN_COLLINEAR &&
            in_bounds(px[TURN_A[k]], py[TURN_A[k]], px[TURN_B[k]], py[TURN_B[k]],
                      px[TURN_C[k]], py[TURN_C[k]]))
          hit = 1'b1;
      end
      return hit;
    endfunction

    function void note_request(seg_pair_t p);
      expected_hits = {expected_hits, predict_hit(p)};
    endfunction

    task check_result(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        report_mismatch("result arrived with no request pending");
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("segments_intersect %b, expected %b", got, want));
        end else if (want) begin
          hits++;
        end else begin
          misses++;
        end
      end
      checked++;
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  seg_pair_t req       = '0;
  logic      in_stall;
  logic      out_valid;
  logic      segments_intersect;
  bit        idle_on   = 1'b0;

  intersect_board board;

  segment_intersection_test #(.COORD_WIDTH(COORD_W)) uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .seg_a_start_x      (req.x[0]),
    .seg_a_start_y      (req.y[0]),
    .seg_a_end_x        (req.x[1]),
    .seg_a_end_y        (req.y[1]),
    .seg_b_start_x      (req.x[2]),
    .seg_b_start_y      (req.y[2]),
    .seg_b_end_x        (req.x[3]),
    .seg_b_end_y        (req.y[3]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .segments_intersect (segments_intersect)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_request(req);
      if (out_valid && !out_stall) board.check_result(segments_intersect);
    end
  end

  // Output back-pressure in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic seg_pair_t pair_of(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.x[0] = ax0[COORD_W-1:0];
    p.y[0] = ay0[COORD_W-1:0];
    p.x[1] = ax1[COORD_W-1:0];
    p.y[1] = ay1[COORD_W-1:0];
    p.x[2] = bx0[COORD_W-1:0];
    p.y[2] = by0[COORD_W-1:0];
    p.x[3] = bx1[COORD_W-1:0];
    p.y[3] = by1[COORD_W-1:0];
    return p;
  endfunction

  // Random pairs are biased toward collinear, touching and degenerate geometry,
  // where a plain uniform draw almost never lands.
  function automatic seg_pair_t random_pair();
    int c[8];
    int base_x, base_y, dx, dy, ex, ey, span, pick, swap;
    base_x = int'($urandom_range(0, 64000)) - 32000;
    base_y = int'($urandom_range(0, 64000)) - 32000;
    dx     = int'($urandom_range(0, 8)) - 4;
    dy     = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(0, 65535)) - 32768;
      end
      2, 3: begin
        for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(0, 12)) - 6;
      end
      4, 5: begin
        for (int i = 0; i < 4; i++) begin
          pick = int'($urandom_range(0, 12)) - 6;
          c[2*i]   = base_x + pick * dx;
          c[2*i+1] = base_y + pick * dy;
        end
      end
      6, 7: begin
        span = $urandom_range(1, 6);
        pick = $urandom_range(0, span);
        c[0] = base_x;
        c[1] = base_y;
        c[2] = base_x + span * dx;
        c[3] = base_y + span * dy;
        c[4] = base_x + pick * dx;
        c[5] = base_y + pick * dy;
        c[6] = c[4] + int'($urandom_range(0, 80)) - 40;
        c[7] = c[5] + int'($urandom_range(0, 80)) - 40;
        if ($urandom_range(0, 1)) begin
          c[6] = c[4];
          c[7] = c[5];
        end
        if ($urandom_range(0, 3) == 0) begin
          c[2] = c[0];
          c[3] = c[1];
        end
      end
      8: begin
        for (int i = 0; i < 8; i++) c[i] = EDGE_VALUES[$urandom_range(0, 7)];
      end
      default: begin
        // Two segments built through one shared point, in random directions.
        ex = int'($urandom_range(0, 8)) - 4;
        ey = int'($urandom_range(0, 8)) - 4;
        span = $urandom_range(0, 6);
        c[0] = base_x - span * dx;
        c[1] = base_y - span * dy;
        span = $urandom_range(0, 6);
        c[2] = base_x + span * dx;
        c[3] = base_y + span * dy;
        span = $urandom_range(0, 6);
        c[4] = base_x - span * ex;
        c[5] = base_y - span * ey;
        span = $urandom_range(0, 6);
        c[6] = base_x + span * ex;
        c[7] = base_y + span * ey;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 4; i++) begin
        swap     = c[i];
        c[i]     = c[i+4];
        c[i+4]   = swap;
      end
    end
    return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drive_pair(seg_pair_t p);
    in_valid <= 1'b1;
    req      <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    seg_pair_t directed[$];
    int        drain_cycles;

    board = new;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed = {directed, pair_of(0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, pair_of(-10, -10, 10, 10, -10, 10, 10, -10)};
    directed = {directed, pair_of(10, 10, -10, -10, 10, -10, -10, 10)};
    directed = {directed, pair_of(0, 0, 10, 0, 0, 1, 10, 1)};
    directed = {directed, pair_of(0, 0, 10, 0, 5, 0, 15, 0)};
    directed = {directed, pair_of(0, 0, 4, 4, 5, 5, 9, 9)};
    directed = {directed, pair_of(0, 0, 4, 4, 4, 4, 8, 8)};
    directed = {directed, pair_of(10, 0, 0, 0, -5, 0, 0, 0)};
    directed = {directed, pair_of(2, 2, 3, 3, 0, 0, 9, 9)};
    directed = {directed, pair_of(0, 0, 10, 0, 5, 5, 5, 0)};
    directed = {directed, pair_of(0, 0, 10, 0, 5, 5, 5, 1)};
    directed = {directed, pair_of(0, 0, 10, 10, 5, 4, 20, 4)};
    directed = {directed, pair_of(3, 3, 3, 3, 0, 0, 6, 6)};
    directed = {directed, pair_of(3, 4, 3, 4, 0, 0, 6, 6)};
    directed = {directed, pair_of(0, -5, 0, 5, 0, 7, 0, 7)};
    directed = {directed, pair_of(1, 1, 1, 1, 2, 2, 2, 2)};
    directed = {directed, pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN)};
    directed = {directed, pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                  -1, -1, 0, 0)};
    directed = {directed, pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN + 1, COORD_MAX - 1, COORD_MAX)};
    directed = {directed, pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN)};
    directed = {directed, pair_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN)};
    directed = {directed, pair_of(-1, -1, -1, -1, -1, -1, -1, -1)};

    foreach (directed[i]) drive_pair(directed[i]);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      // Idling comes and goes in stretches and stops for the final stretch.
      idle_on = (i % 150 < 100) && (i < RANDOM_PAIRS - 50);
      if (idle_on && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 8));
      drive_pair(random_pair());
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    drain_cycles = 0;
    while (board.expected_hits.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (board.expected_hits.size() != 0)
      board.report_mismatch($sformatf("%0d requests never answered",
                                      board.expected_hits.size()));

    $display("Checked %0d segment pairs: %0d intersecting, %0d disjoint.",
             board.checked, board.hits, board.misses);
    $display("Mix covered crossings, collinear overlaps, touches, points and extreme coordinates.");
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/sit_pkg.sv
sv/sit_diff.sv
sv/sit_cross.sv
sv/sit_decide.sv
sv/segment_intersection_test.sv
sv/sit_checker.sv
bench/tb.sv
